FILE: hdl/bta_pkg.sv
// bta_pkg: shared types and constants for the associative branch target buffer
// depends on nothing; imported by every module of the block
`default_nettype none

package bta_pkg;

  // address and data width of pc, target and result fields
  localparam int unsigned ADDR_W = 32;

  // distance to the next sequential instruction
  localparam logic [ADDR_W-1:0] PC_STEP = 32'd4;

  // operation codes carried in the action field
  typedef enum logic [1:0] {
    ACT_LOOKUP     = 2'd0,
    ACT_SENDOUT    = 2'd1,
    ACT_MISPREDICT = 2'd2,
    ACT_UPDATE     = 2'd3
  } action_t;

  // classified transaction handed from the front to the back
  typedef struct packed {
    action_t           act;
    logic [ADDR_W-1:0] pc;
    logic              taken;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] seq_pc;
  } bta_item_t;

endpackage

`default_nettype wire

FILE: hdl/bta_front.sv
// bta_front: accepts input transactions, decodes the action, precomputes pc+4 for lookups
// and holds them in a two-entry queue; depends on bta_pkg
`default_nettype none

module bta_front
  import bta_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        action,
  input  wire logic [ADDR_W-1:0] pc,
  input  wire logic              taken,
  input  wire logic [ADDR_W-1:0] target,
  output logic                   q_valid,
  input  wire logic              q_pop,
  output bta_item_t              q_item
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  bta_item_t                q_mem [QDEPTH];
  logic      [QPTR_W-1:0]   wr_ptr;
  logic      [QPTR_W-1:0]   rd_ptr;
  logic      [QCNT_W-1:0]   count;
  logic      [QCNT_W-1:0]   count_next;
  logic                     push;
  bta_item_t                item_new;

  // classify the incoming transaction
  always_comb begin
    item_new.act    = action_t'(action);
    item_new.pc     = pc;
    item_new.taken  = taken;
    item_new.target = target;
    item_new.seq_pc = (action_t'(action) == ACT_LOOKUP) ? pc + PC_STEP : '0;
  end

  // queue handshake
  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = q_mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + QCNT_W'(1);
    end else if (q_pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item_new;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bta_back.sv
// bta_back: tag/target stores, parallel compare, priority encode and result
// register; executes one queued transaction at a time; depends on bta_pkg
`default_nettype none

module bta_back
  import bta_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire bta_item_t         q_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ADDR_W-1:0]      sequential_pc,
  output logic [ADDR_W-1:0]      predicted_target,
  output logic                   was_hit
);

  localparam int unsigned IDX_W = $clog2(NUM_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  state_t                  state;
  bta_item_t               item;
  logic [ADDR_W-1:0]       tag_store    [NUM_ENTRIES];
  logic [ADDR_W-1:0]       target_store [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0]  slot_valid;
  logic [NUM_ENTRIES-1:0]  hit_match;
  logic [NUM_ENTRIES-1:0]  empty_match;
  logic [NUM_ENTRIES-1:0]  dup_match;
  logic                    hit_pending;
  logic [IDX_W-1:0]        hit_slot;
  logic [IDX_W-1:0]        hit_idx;
  logic [IDX_W-1:0]        empty_idx;
  logic                    any_hit;
  logic                    any_empty;
  logic                    do_insert;
  logic                    go;
  logic [ADDR_W-1:0]       slot_target;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign go    = (state == S_EXEC) && (!out_valid || !out_stall);

  // lowest matching slot for lookup and lowest empty slot for insert
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (hit_match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (empty_match[i]) begin
        empty_idx = IDX_W'(i);
      end
    end
  end

  assign any_hit   = |hit_match;
  assign any_empty = |empty_match;
  assign do_insert = (item.act == ACT_UPDATE) && item.taken && !(|dup_match) && any_empty;

  // target of the remembered slot; an invalid slot reads as zero
  assign slot_target = slot_valid[hit_slot] ? target_store[hit_slot] : '0;

  // sequencer, hit tracking, slot valid bits and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      hit_pending <= 1'b0;
      hit_slot    <= '0;
      slot_valid  <= '0;
    end else begin
      // drop the taken result unless a new one replaces it this cycle
      if (out_valid && !out_stall && !go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (go) begin
            state            <= S_IDLE;
            out_valid        <= 1'b1;
            sequential_pc    <= item.seq_pc;
            predicted_target <= '0;
            was_hit          <= 1'b0;
            case (item.act)
              ACT_LOOKUP: begin
                if (any_hit) begin
                  hit_pending <= 1'b1;
                  hit_slot    <= hit_idx;
                end
              end
              ACT_SENDOUT: begin
                if (hit_pending) begin
                  predicted_target <= slot_target;
                  was_hit          <= 1'b1;
                end
                hit_pending <= 1'b0;
              end
              ACT_MISPREDICT: begin
                slot_valid[hit_slot] <= 1'b0;
              end
              default: begin
                if (do_insert) begin
                  slot_valid[empty_idx] <= 1'b1;
                end
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // current transaction and parallel tag compare
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
    end
    if (state == S_CMP) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        hit_match[i]   <= (slot_valid[i] ? tag_store[i] : '0) == item.pc;
        empty_match[i] <= !slot_valid[i] || (tag_store[i] == '0);
        dup_match[i]   <= ((slot_valid[i] ? tag_store[i] : '0) == item.pc) &&
                          ((slot_valid[i] ? target_store[i] : '0) == item.target);
      end
    end
  end

  // pair storage, written on insert
  always_ff @(posedge clk) begin
    if (go && do_insert) begin
      tag_store[empty_idx]    <= item.pc;
      target_store[empty_idx] <= item.target;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/branch_target_buffer_assoc_top.sv
// path: front queue, then item register (S_IDLE), compare registers (S_CMP) and
// result register (S_EXEC); the back sequencer takes one transaction at a time
// (queue pop, parallel tag compare, priority encode and store update)
// the two-entry front queue keeps accepting while the back or the output waits, until full
// reset: synchronous; empties the queue, clears all slot valid bits and the hit flag
// directly, with no clearing pass
`default_nettype none

module branch_target_buffer_assoc_top
  import bta_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        action,
  input  wire logic [ADDR_W-1:0] pc,
  input  wire logic              taken,
  input  wire logic [ADDR_W-1:0] target,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ADDR_W-1:0]      sequential_pc,
  output logic [ADDR_W-1:0]      predicted_target,
  output logic                   was_hit
);

  logic      q_valid;
  logic      q_pop;
  bta_item_t q_item;

  // front: accept and classify
  bta_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .pc       (pc),
    .taken    (taken),
    .target   (target),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // back: search, update and result register
  bta_back #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_item           (q_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .sequential_pc    (sequential_pc),
    .predicted_target (predicted_target),
    .was_hit          (was_hit)
  );

endmodule

`default_nettype wire

FILE: hdl/bta_checker.sv
// bta_checker: port-level checks of the branch target buffer over time
// depends on bta_pkg; bound to branch_target_buffer_assoc_top
`default_nettype none

module bta_checker
  import bta_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [ADDR_W-1:0] sequential_pc,
  input wire logic [ADDR_W-1:0] predicted_target,
  input wire logic              was_hit
);

  // no result is offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sequential_pc) &&
      $stable(predicted_target) && $stable(was_hit))
    else $error("stalled result changed");

  // a hit comes only from a sendout, which carries no sequential pc
  a_hit_no_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_hit |-> sequential_pc == '0)
    else $error("hit reported with a sequential pc");

  // a miss never carries a predicted target
  a_miss_no_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && !was_hit |-> predicted_target == '0)
    else $error("predicted target without a hit");

endmodule

bind branch_target_buffer_assoc_top bta_checker u_bta_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .sequential_pc    (sequential_pc),
  .predicted_target (predicted_target),
  .was_hit          (was_hit)
);

`default_nettype wire

FILE: verif/btb_access_checker.sv
`timescale 1ns / 1ps
// btb_access_checker: tracks tag/target table state of the associative branch target buffer,
// predicts the response of every accepted transaction and compares it at the output channel
// depends on bta_pkg (action codes, address width, sequential step)

module btb_access_checker
  import bta_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [1:0]        action,
  input  wire logic [ADDR_W-1:0] pc,
  input  wire logic              taken,
  input  wire logic [ADDR_W-1:0] target,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [ADDR_W-1:0] sequential_pc,
  input  wire logic [ADDR_W-1:0] predicted_target,
  input  wire logic              was_hit,
  output int                     mismatch_cnt,
  output int                     checked_cnt,
  output int                     hit_cnt,
  output int                     drop_cnt,
  output int                     outstanding
);

  localparam int unsigned SLOT_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  typedef struct packed {
    logic [ADDR_W-1:0] seq_pc;
    logic [ADDR_W-1:0] pred_target;
    logic              hit;
  } btb_response_t;

  // shadow copy of the table and the remembered hit
  logic [ADDR_W-1:0] tag_mem  [NUM_ENTRIES];
  logic [ADDR_W-1:0] dest_mem [NUM_ENTRIES];
  logic              pend_hit;
  logic [SLOT_W-1:0] pend_slot;

  // responses owed by the block, oldest first
  btb_response_t response_q [$];

  initial begin
    mismatch_cnt = 0;
    checked_cnt  = 0;
    hit_cnt      = 0;
    drop_cnt     = 0;
    outstanding  = 0;
  end

  // apply one transaction to the shadow table and work out its response
  task automatic compute_response(input action_t act, input logic [ADDR_W-1:0] addr,
                                  input logic tk, input logic [ADDR_W-1:0] dest,
                                  output btb_response_t resp);
    int   slot;
    logic dup;
    resp = '0;
    slot = -1;
    dup  = 1'b0;
    case (act)
      ACT_LOOKUP: begin
        // scan downward so the lowest matching slot wins
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
          if (tag_mem[i] == addr) slot = i;
        end
        if (slot >= 0) begin
          pend_hit  = 1'b1;
          pend_slot = SLOT_W'(slot);
        end
        resp.seq_pc = addr + PC_STEP;
      end
      ACT_SENDOUT: begin
        if (pend_hit) begin
          resp.pred_target = dest_mem[pend_slot];
          resp.hit         = 1'b1;
        end
        pend_hit = 1'b0;
      end
      ACT_MISPREDICT: begin
        // clears the remembered slot even with no hit pending
        tag_mem[pend_slot]  = '0;
        dest_mem[pend_slot] = '0;
      end
      default: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (tag_mem[i] == addr && dest_mem[i] == dest) dup = 1'b1;
        end
        if (tk && !dup) begin
          for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (tag_mem[i] == '0) slot = i;
          end
          if (slot >= 0) begin
            tag_mem[slot]  = addr;
            dest_mem[slot] = dest;
          end else begin
            drop_cnt++;
          end
        end
      end
    endcase
  endtask

  // compare finished transactions first, then record the newly accepted one
  always @(posedge clk) begin
    btb_response_t want;
    btb_response_t got;
    if (rst) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        tag_mem[i]  = '0;
        dest_mem[i] = '0;
      end
      pend_hit  = 1'b0;
      pend_slot = '0;
      response_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{sequential_pc, predicted_target, was_hit};
        if (response_q.size() == 0) begin
          $display("%0t: unexpected response seq_pc=%h predicted_target=%h was_hit=%b",
                   $realtime, got.seq_pc, got.pred_target, got.hit);
          mismatch_cnt++;
        end else begin
          want = response_q.pop_front();
          checked_cnt++;
          if (got.seq_pc !== want.seq_pc) begin
            $display("%0t: sequential_pc expected %h actual %h",
                     $realtime, want.seq_pc, got.seq_pc);
            mismatch_cnt++;
          end
          if (got.pred_target !== want.pred_target) begin
            $display("%0t: predicted_target expected %h actual %h",
                     $realtime, want.pred_target, got.pred_target);
            mismatch_cnt++;
          end
          if (got.hit !== want.hit) begin
            $display("%0t: was_hit expected %b actual %b", $realtime, want.hit, got.hit);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        compute_response(action_t'(action), pc, taken, target, want);
        if (want.hit) hit_cnt++;
        response_q.push_back(want);
      end
    end
    outstanding <= response_q.size();
  end

endmodule

FILE: verif/branch_target_buffer_assoc_top_tb.sv
`timescale 1ns / 1ps
// branch_target_buffer_assoc_top_tb: clock, reset, stimulus and verdict for the branch target buffer
// depends on bta_pkg, branch_target_buffer_assoc_top and btb_access_checker

module branch_target_buffer_assoc_top_tb;
  import bta_pkg::*;

  localparam int unsigned NUM_ENTRIES  = 32;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned POOL_SIZE    = 48;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES  = 8;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [1:0]        action    = ACT_LOOKUP;
  logic [ADDR_W-1:0] pc        = '0;
  logic              taken     = 1'b0;
  logic [ADDR_W-1:0] target    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] sequential_pc;
  logic [ADDR_W-1:0] predicted_target;
  logic              was_hit;

  logic idle_on      = 1'b0;
  int   stall_left   = 0;
  int   quiet_cycles = 0;
  int   sent_cnt     = 0;
  int   mismatch_cnt;
  int   checked_cnt;
  int   hit_cnt;
  int   drop_cnt;
  int   outstanding;

  // branch addresses and per-branch targets reused so lookups hit and pairs repeat
  logic [ADDR_W-1:0] pc_pool   [POOL_SIZE];
  logic [ADDR_W-1:0] dest_pool [POOL_SIZE][4];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  branch_target_buffer_assoc_top #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .pc              (pc),
    .taken           (taken),
    .target          (target),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sequential_pc   (sequential_pc),
    .predicted_target(predicted_target),
    .was_hit         (was_hit)
  );

  btb_access_checker #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .pc              (pc),
    .taken           (taken),
    .target          (target),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sequential_pc   (sequential_pc),
    .predicted_target(predicted_target),
    .was_hit         (was_hit),
    .mismatch_cnt    (mismatch_cnt),
    .checked_cnt     (checked_cnt),
    .hit_cnt         (hit_cnt),
    .drop_cnt        (drop_cnt),
    .outstanding     (outstanding)
  );

  // receiver backpressure in random-length bursts while idle_on is set
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 11);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // one transaction on the input channel, with an occasional idle burst ahead of it
  task automatic issue_access(input action_t act, input logic [ADDR_W-1:0] addr,
                              input logic tk, input logic [ADDR_W-1:0] dest);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    pc       <= addr;
    taken    <= tk;
    target   <= dest;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
  endtask

  // hold the input channel until every owed response is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int                base;
    int                done;
    int                k;
    int                pick;
    logic [ADDR_W-1:0] addr;
    logic              pressure_done;

    pressure_done = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pc_pool[i] = $urandom;
      for (int j = 0; j < 4; j++) dest_pool[i][j] = $urandom;
    end
    pc_pool[0] = '0;
    pc_pool[1] = 32'hFFFF_FFFC;
    pc_pool[2] = 32'hFFFF_FFFF;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-slot match on pc zero, wraparound, duplicates, mispredict paths
    issue_access(ACT_LOOKUP, '0, 1'b0, '0);
    issue_access(ACT_SENDOUT, '0, 1'b0, '0);
    issue_access(ACT_SENDOUT, '0, 1'b0, '0);
    issue_access(ACT_LOOKUP, 32'hFFFF_FFFC, 1'b1, 32'hFFFF_FFFF);
    issue_access(ACT_LOOKUP, 32'hFFFF_FFFF, 1'b0, '0);
    issue_access(ACT_UPDATE, 32'h0040_1A2C, 1'b0, 32'h0040_2000);
    issue_access(ACT_UPDATE, 32'h0040_1A2C, 1'b1, 32'h0040_2000);
    issue_access(ACT_UPDATE, 32'h0040_1A2C, 1'b1, 32'h0040_2000);
    issue_access(ACT_UPDATE, 32'h0040_1A2C, 1'b1, 32'h0040_3F00);
    issue_access(ACT_UPDATE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    issue_access(ACT_LOOKUP, 32'h0040_1A2C, 1'b0, '0);
    issue_access(ACT_SENDOUT, '0, 1'b0, '0);
    issue_access(ACT_LOOKUP, 32'hFFFF_FFFF, 1'b0, '0);
    issue_access(ACT_MISPREDICT, '0, 1'b0, '0);
    issue_access(ACT_SENDOUT, '0, 1'b0, '0);
    issue_access(ACT_MISPREDICT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    issue_access(ACT_UPDATE, '0, 1'b1, 32'h1234_5678);
    issue_access(ACT_LOOKUP, '0, 1'b0, '0);
    issue_access(ACT_SENDOUT, '0, 1'b0, '0);
    issue_access(ACT_UPDATE, '0, 1'b1, '0);
    issue_access(ACT_UPDATE, 32'h8000_0001, 1'b1, '0);
    issue_access(ACT_LOOKUP, 32'h0040_1A2C, 1'b0, '0);
    issue_access(ACT_SENDOUT, '0, 1'b0, '0);
    wait_drained();

    // random: mostly lookup/sendout pairs and updates over the address pool, some noise
    base = sent_cnt;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      idle_on <= (done < 300) || (done >= 420 && done < 800);
      if (!pressure_done && done >= 500) begin
        wait_drained();
        pressure_done = 1'b1;
      end
      k    = $urandom_range(0, POOL_SIZE - 1);
      addr = pc_pool[k];
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        issue_access(action_t'($urandom_range(0, 3)), $urandom,
                     1'($urandom_range(0, 1)), $urandom);
      end else if (pick < 40) begin
        issue_access(ACT_UPDATE, addr, $urandom_range(0, 5) != 0,
                     dest_pool[k][$urandom_range(0, 3)]);
      end else if (pick < 72) begin
        issue_access(ACT_LOOKUP, addr, 1'($urandom_range(0, 1)), $urandom);
        issue_access(ACT_SENDOUT, $urandom, 1'($urandom_range(0, 1)), $urandom);
      end else if (pick < 82) begin
        issue_access(ACT_LOOKUP, addr, 1'b0, '0);
      end else if (pick < 91) begin
        issue_access(ACT_SENDOUT, '0, 1'b0, '0);
      end else begin
        issue_access(ACT_LOOKUP, addr, 1'b0, '0);
        issue_access(ACT_MISPREDICT, $urandom, 1'($urandom_range(0, 1)), $urandom);
        issue_access(ACT_SENDOUT, '0, 1'b0, '0);
      end
      done = sent_cnt - base;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d transactions with %0d responses compared", sent_cnt, checked_cnt);
    $display("sendout hits %0d, inserts dropped on a full table %0d", hit_cnt, drop_cnt);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/bta_pkg.sv
hdl/bta_front.sv
hdl/bta_back.sv
hdl/branch_target_buffer_assoc_top.sv
hdl/bta_checker.sv
verif/btb_access_checker.sv
verif/branch_target_buffer_assoc_top_tb.sv
